// ===== rtl/core/pose_compose_2d_normalized_top_defines.svh =====
// Assertion macros for the pose composition block.
// Used by the top level only; no other dependencies.
`ifndef POSE_COMPOSE_2D_NORMALIZED_TOP_DEFINES_SVH
`define POSE_COMPOSE_2D_NORMALIZED_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PCN_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pcn: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define PCN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcn: next-cycle check failed");

`endif

// ===== rtl/core/pcn_pkg.sv =====
// Package for the pose composition block: widths, latencies and stage types.
// No dependencies; used by pcn_norm and the top level.
package pcn_pkg;

   localparam int PW        = 32;
   localparam int RW        = 16;
   localparam int FRAC      = RW - 2;
   localparam int HX        = 32 - RW;
   localparam int NW        = 2 * (RW + HX);
   localparam int SQ_STEPS  = NW / 2;
   localparam int LW        = NW / 2;
   localparam int DQ        = RW;
   localparam int DNW       = LW + DQ;
   localparam int NORM_LAT  = SQ_STEPS + DQ + 4;
   localparam int TOP_LAT   = NORM_LAT + 3;
   localparam int PROD_W    = RW + PW;
   localparam int TW        = PROD_W + 2 - FRAC;
   localparam int RPW       = 2 * RW + 2 - FRAC;

   typedef struct packed {
      logic [RW-1:0] mag_c;
      logic [RW-1:0] mag_s;
      logic          neg_c;
      logic          neg_s;
      logic          zero;
   } norm_side_type;

   typedef struct packed {
      logic signed [PW-1:0] px;
      logic signed [PW-1:0] py;
      logic signed [PW-1:0] ox;
      logic signed [PW-1:0] oy;
   } pos_word_type;

endpackage

// ===== rtl/core/pose_compose_2d_normalized_top.sv =====
// Pose composition top level: two normalizers, rotate, add and saturate.
// Depends on pcn_pkg, pcn_norm and pose_compose_2d_normalized_top_defines.svh.
//
// Usage:
//  - Request channel (req_*): parent pose and child offset, one word per
//    accepted cycle (req_valid high, req_stall low).
//  - Response channel (rsp_*): the composed world pose, one word per request,
//    in request order.
//  - Pipeline: 55 register stages (34 for the squares and square root
//    chain, 18 for the dividers and clamp, 2 for rotation products and
//    rounding, 1 for the add and saturate).
//  - Throughput: one word per cycle while rsp_stall does not hold a valid
//    response; every stage is a register and the whole pipeline advances together.
//  - When the receiver stalls a valid response, the pipeline holds and
//    req_stall rises in the same cycle; no word is lost or repeated.
//  - Reset clears all valid bits; payload registers are left as they are.
`include "pose_compose_2d_normalized_top_defines.svh"
module pose_compose_2d_normalized_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [pcn_pkg::PW-1:0] req_parent_x,
   input  logic signed [pcn_pkg::PW-1:0] req_parent_y,
   input  logic signed [pcn_pkg::RW-1:0] req_parent_cos,
   input  logic signed [pcn_pkg::RW-1:0] req_parent_sin,
   input  logic signed [pcn_pkg::PW-1:0] req_offset_x,
   input  logic signed [pcn_pkg::PW-1:0] req_offset_y,
   input  logic signed [pcn_pkg::RW-1:0] req_own_cos,
   input  logic signed [pcn_pkg::RW-1:0] req_own_sin,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [pcn_pkg::PW-1:0] rsp_world_x,
   output logic signed [pcn_pkg::PW-1:0] rsp_world_y,
   output logic signed [pcn_pkg::RW-1:0] rsp_world_cos,
   output logic signed [pcn_pkg::RW-1:0] rsp_world_sin
);
   import pcn_pkg::*;

   localparam logic signed [TW:0] SAT_HI =
      {{(TW+2-PW){1'b0}}, {(PW-1){1'b1}}};
   localparam logic signed [TW:0] SAT_LO = ~SAT_HI;
   localparam logic signed [RPW-1:0] RP_ONE =
      {{(RPW-FRAC-1){1'b0}}, 1'b1, {FRAC{1'b0}}};
   localparam logic signed [RW-1:0] ROT_ONE =
      {{(RW-FRAC-1){1'b0}}, 1'b1, {FRAC{1'b0}}};
   localparam logic signed [PROD_W+1:0] RND_P = (PROD_W+2)'(1) << (FRAC - 1);
   localparam logic signed [2*RW+1:0]   RND_R = (2*RW+2)'(1) << (FRAC - 1);

   logic                 en;
   logic                 vld_ff [0:TOP_LAT-1];
   pos_word_type         pos_ff [0:NORM_LAT-1];
   logic signed [RW-1:0] pc, ps, oc, os;

   logic signed [PROD_W-1:0] pcx_ff, psy_ff, psx_ff, pcy_ff;
   logic signed [2*RW-1:0]   pcoc_ff, psos_ff, psoc_ff, pcos_ff;
   logic signed [PW-1:0]     r1_px_ff, r1_py_ff;

   logic signed [PROD_W+1:0] sx_in, sy_in;
   logic signed [2*RW+1:0]   sc_in, ss_in;
   logic signed [TW-1:0]     tx_ff, ty_ff;
   logic signed [RPW-1:0]    tc_ff, ts_ff;
   logic signed [PW-1:0]     r2_px_ff, r2_py_ff;

   logic signed [TW:0]       wx_in, wy_in;
   logic signed [PW-1:0]     world_x_ff, world_y_ff;
   logic signed [RW-1:0]     world_cos_ff, world_sin_ff;

   assign en        = !(vld_ff[TOP_LAT-1] && rsp_stall);
   assign req_stall = !en;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int v = 0; v < TOP_LAT; v++) begin
            vld_ff[v] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int v = 1; v < TOP_LAT; v++) begin
            vld_ff[v] <= vld_ff[v-1];
         end
      end
   end

   // positions wait for the normalizers
   always_ff @(posedge clock) begin
      if (en) begin
         pos_ff[0].px <= req_parent_x;
         pos_ff[0].py <= req_parent_y;
         pos_ff[0].ox <= req_offset_x;
         pos_ff[0].oy <= req_offset_y;
         for (int p = 1; p < NORM_LAT; p++) begin
            pos_ff[p] <= pos_ff[p-1];
         end
      end
   end

   pcn_norm u_norm_parent (
      .clock    (clock),
      .en       (en),
      .in_cos   (req_parent_cos),
      .in_sin   (req_parent_sin),
      .unit_cos (pc),
      .unit_sin (ps)
   );

   pcn_norm u_norm_own (
      .clock    (clock),
      .en       (en),
      .in_cos   (req_own_cos),
      .in_sin   (req_own_sin),
      .unit_cos (oc),
      .unit_sin (os)
   );

   // products
   always_ff @(posedge clock) begin
      if (en) begin
         pcx_ff   <= PROD_W'(pc) * PROD_W'(pos_ff[NORM_LAT-1].ox);
         psy_ff   <= PROD_W'(ps) * PROD_W'(pos_ff[NORM_LAT-1].oy);
         psx_ff   <= PROD_W'(ps) * PROD_W'(pos_ff[NORM_LAT-1].ox);
         pcy_ff   <= PROD_W'(pc) * PROD_W'(pos_ff[NORM_LAT-1].oy);
         pcoc_ff  <= (2*RW)'(pc) * (2*RW)'(oc);
         psos_ff  <= (2*RW)'(ps) * (2*RW)'(os);
         psoc_ff  <= (2*RW)'(ps) * (2*RW)'(oc);
         pcos_ff  <= (2*RW)'(pc) * (2*RW)'(os);
         r1_px_ff <= pos_ff[NORM_LAT-1].px;
         r1_py_ff <= pos_ff[NORM_LAT-1].py;
      end
   end

   assign sx_in = (PROD_W+2)'(pcx_ff) - (PROD_W+2)'(psy_ff) + RND_P;
   assign sy_in = (PROD_W+2)'(psx_ff) + (PROD_W+2)'(pcy_ff) + RND_P;
   assign sc_in = (2*RW+2)'(pcoc_ff) - (2*RW+2)'(psos_ff) + RND_R;
   assign ss_in = (2*RW+2)'(psoc_ff) + (2*RW+2)'(pcos_ff) + RND_R;

   // round to the rotation scale
   always_ff @(posedge clock) begin
      if (en) begin
         tx_ff    <= sx_in[PROD_W+1:FRAC];
         ty_ff    <= sy_in[PROD_W+1:FRAC];
         tc_ff    <= sc_in[2*RW+1:FRAC];
         ts_ff    <= ss_in[2*RW+1:FRAC];
         r2_px_ff <= r1_px_ff;
         r2_py_ff <= r1_py_ff;
      end
   end

   assign wx_in = (TW+1)'(r2_px_ff) + (TW+1)'(tx_ff);
   assign wy_in = (TW+1)'(r2_py_ff) + (TW+1)'(ty_ff);

   // add, saturate, clamp
   always_ff @(posedge clock) begin
      if (en) begin
         if (wx_in > SAT_HI) begin
            world_x_ff <= PW'(SAT_HI);
         end else if (wx_in < SAT_LO) begin
            world_x_ff <= PW'(SAT_LO);
         end else begin
            world_x_ff <= PW'(wx_in);
         end
         if (wy_in > SAT_HI) begin
            world_y_ff <= PW'(SAT_HI);
         end else if (wy_in < SAT_LO) begin
            world_y_ff <= PW'(SAT_LO);
         end else begin
            world_y_ff <= PW'(wy_in);
         end
         if (tc_ff > RP_ONE) begin
            world_cos_ff <= ROT_ONE;
         end else if (tc_ff < -RP_ONE) begin
            world_cos_ff <= -ROT_ONE;
         end else begin
            world_cos_ff <= RW'(tc_ff);
         end
         if (ts_ff > RP_ONE) begin
            world_sin_ff <= ROT_ONE;
         end else if (ts_ff < -RP_ONE) begin
            world_sin_ff <= -ROT_ONE;
         end else begin
            world_sin_ff <= RW'(ts_ff);
         end
      end
   end

   assign rsp_valid     = vld_ff[TOP_LAT-1];
   assign rsp_world_x   = world_x_ff;
   assign rsp_world_y   = world_y_ff;
   assign rsp_world_cos = world_cos_ff;
   assign rsp_world_sin = world_sin_ff;

   `PCN_ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && !req_stall, vld_ff[0])
   `PCN_ASSERT_NOW(a_cos_range, clock, reset, rsp_valid, rsp_world_cos <= ROT_ONE && rsp_world_cos >= -ROT_ONE)
   `PCN_ASSERT_NOW(a_rot_nonzero, clock, reset, rsp_valid, rsp_world_cos != '0 || rsp_world_sin != '0)

endmodule

// ===== rtl/core/pcn_norm.sv =====
// Rotation pair normalizer: squares, pipelined integer square root, two
// pipelined restoring dividers and a clamp. Depends on pcn_pkg.
module pcn_norm (
   input  logic                        clock,
   input  logic                        en,
   input  logic signed [pcn_pkg::RW-1:0] in_cos,
   input  logic signed [pcn_pkg::RW-1:0] in_sin,
   output logic signed [pcn_pkg::RW-1:0] unit_cos,
   output logic signed [pcn_pkg::RW-1:0] unit_sin
);
   import pcn_pkg::*;

   localparam logic [DQ-1:0] Q_ONE = {{(DQ-FRAC-1){1'b0}}, 1'b1, {FRAC{1'b0}}};

   logic [RW-1:0]     mag_c_in, mag_s_in;
   logic [2*RW-1:0]   sqc_ff, sqs_ff, n_sum;
   norm_side_type     s0_side_ff;

   logic [NW-1:0]     sq_rem_ff  [0:SQ_STEPS];
   logic [NW-1:0]     sq_root_ff [0:SQ_STEPS];
   norm_side_type     sq_side_ff [0:SQ_STEPS];

   logic [DNW-1:0]    dv_rem_c_ff [0:DQ];
   logic [DNW-1:0]    dv_rem_s_ff [0:DQ];
   logic [DQ-1:0]     dv_q_c_ff   [0:DQ];
   logic [DQ-1:0]     dv_q_s_ff   [0:DQ];
   logic [LW-1:0]     dv_len_ff   [0:DQ];
   norm_side_type     dv_side_ff  [0:DQ];

   logic [LW-1:0]     len_w;
   logic [DQ-1:0]     qc_cl, qs_cl;
   logic signed [RW-1:0] unit_cos_ff, unit_sin_ff;

   assign mag_c_in = in_cos[RW-1] ? RW'(-in_cos) : RW'(in_cos);
   assign mag_s_in = in_sin[RW-1] ? RW'(-in_sin) : RW'(in_sin);
   assign n_sum    = sqc_ff + sqs_ff;

   // squares
   always_ff @(posedge clock) begin
      if (en) begin
         sqc_ff           <= mag_c_in * mag_c_in;
         sqs_ff           <= mag_s_in * mag_s_in;
         s0_side_ff.mag_c <= mag_c_in;
         s0_side_ff.mag_s <= mag_s_in;
         s0_side_ff.neg_c <= in_cos[RW-1];
         s0_side_ff.neg_s <= in_sin[RW-1];
         s0_side_ff.zero  <= (in_cos == '0) && (in_sin == '0);
      end
   end

   // sum of squares, load root
   always_ff @(posedge clock) begin
      if (en) begin
         sq_rem_ff[0]       <= {n_sum, {(2*HX){1'b0}}};
         sq_root_ff[0]      <= '0;
         sq_side_ff[0]      <= s0_side_ff;
      end
   end

   for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
      localparam int SH = NW - 2 - 2 * i;
      logic [NW-1:0] bit_w, trial_w;
      assign bit_w   = {{(NW-1){1'b0}}, 1'b1} << SH;
      assign trial_w = sq_root_ff[i] + bit_w;
      always_ff @(posedge clock) begin
         if (en) begin
            if (sq_rem_ff[i] >= trial_w) begin
               sq_rem_ff[i+1]  <= sq_rem_ff[i] - trial_w;
               sq_root_ff[i+1] <= (sq_root_ff[i] >> 1) + bit_w;
            end else begin
               sq_rem_ff[i+1]  <= sq_rem_ff[i];
               sq_root_ff[i+1] <= sq_root_ff[i] >> 1;
            end
            sq_side_ff[i+1] <= sq_side_ff[i];
         end
      end
   end

   assign len_w = sq_root_ff[SQ_STEPS][LW-1:0];

   // divider load: magnitude scaled plus half length
   always_ff @(posedge clock) begin
      if (en) begin
         dv_rem_c_ff[0] <= DNW'({sq_side_ff[SQ_STEPS].mag_c, {(FRAC+HX){1'b0}}})
                           + DNW'(len_w >> 1);
         dv_rem_s_ff[0] <= DNW'({sq_side_ff[SQ_STEPS].mag_s, {(FRAC+HX){1'b0}}})
                           + DNW'(len_w >> 1);
         dv_q_c_ff[0]   <= '0;
         dv_q_s_ff[0]   <= '0;
         dv_len_ff[0]   <= len_w;
         dv_side_ff[0]  <= sq_side_ff[SQ_STEPS];
      end
   end

   for (genvar j = 0; j < DQ; j++) begin : g_dv
      localparam int K = DQ - 1 - j;
      logic [DNW-1:0] div_w;
      assign div_w = DNW'(dv_len_ff[j]) << K;
      always_ff @(posedge clock) begin
         if (en) begin
            if (dv_rem_c_ff[j] >= div_w) begin
               dv_rem_c_ff[j+1] <= dv_rem_c_ff[j] - div_w;
               dv_q_c_ff[j+1]   <= dv_q_c_ff[j] | (DQ'(1) << K);
            end else begin
               dv_rem_c_ff[j+1] <= dv_rem_c_ff[j];
               dv_q_c_ff[j+1]   <= dv_q_c_ff[j];
            end
            if (dv_rem_s_ff[j] >= div_w) begin
               dv_rem_s_ff[j+1] <= dv_rem_s_ff[j] - div_w;
               dv_q_s_ff[j+1]   <= dv_q_s_ff[j] | (DQ'(1) << K);
            end else begin
               dv_rem_s_ff[j+1] <= dv_rem_s_ff[j];
               dv_q_s_ff[j+1]   <= dv_q_s_ff[j];
            end
            dv_len_ff[j+1]  <= dv_len_ff[j];
            dv_side_ff[j+1] <= dv_side_ff[j];
         end
      end
   end

   assign qc_cl = (dv_q_c_ff[DQ] > Q_ONE) ? Q_ONE : dv_q_c_ff[DQ];
   assign qs_cl = (dv_q_s_ff[DQ] > Q_ONE) ? Q_ONE : dv_q_s_ff[DQ];

   // clamp, sign, identity for a zero pair
   always_ff @(posedge clock) begin
      if (en) begin
         if (dv_side_ff[DQ].zero) begin
            unit_cos_ff <= RW'(Q_ONE);
            unit_sin_ff <= '0;
         end else begin
            unit_cos_ff <= dv_side_ff[DQ].neg_c ? RW'(-qc_cl) : RW'(qc_cl);
            unit_sin_ff <= dv_side_ff[DQ].neg_s ? RW'(-qs_cl) : RW'(qs_cl);
         end
      end
   end

   assign unit_cos = unit_cos_ff;
   assign unit_sin = unit_sin_ff;

endmodule
